### rtl/core/icacc_pkg.sv
package icacc_pkg;

    localparam int LABEL_W = 10;
    localparam int PID_W   = 16;
    localparam int DIM_W   = 7;
    localparam int COORD_W = 16;
    localparam int CNT_W   = 17;
    localparam int SUM_W   = 40;
    localparam int MAP_W   = LABEL_W + 1;
    localparam int SADDR_W = LABEL_W + DIM_W;
    localparam int DIVC_W  = 6;

    localparam int NUM_CLUSTERS = 1 << LABEL_W;
    localparam int POINT_SLOTS  = 1 << PID_W;
    localparam int NUM_SUMS     = 1 << SADDR_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_MISSING = 1'b1;

endpackage

### rtl/core/incremental_centroid_accumulator_core.sv
// incremental centroid accumulator
// input channel: i_valid / o_stall carries one coordinate item of an insert or
// delete request (type, point id, label, coordinate index, coordinate value);
// an item is taken at a clock edge with i_valid high and o_stall low
// output channel: o_valid / i_stall returns exactly one result item per input
// item: status, cluster, member count, center coordinate and index echo
// one item is worked at a time; an item that updates a cluster passes
// through the 40-step restoring divider that forms sum / max(count, 1),
// while a failed delete goes straight to the output register
// the next item is accepted in the cycle after the previous result is loaded
// into the output register, so a new item can be in work while a result waits
// reset (i_rst_n low, synchronous) starts a clearing pass over the point
// map, the coordinate sums and the member counts; o_stall stays high during
// the pass
// when the receiver holds i_stall, the result register keeps its item and a
// finished item waits in the block until the register frees
module incremental_centroid_accumulator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic [icacc_pkg::PID_W-1:0]         i_point_id,
    input  logic [icacc_pkg::LABEL_W-1:0]       i_cluster_label,
    input  logic [icacc_pkg::DIM_W-1:0]         i_coord_index,
    input  logic signed [icacc_pkg::COORD_W-1:0] i_coord_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_status,
    output logic [icacc_pkg::LABEL_W-1:0]       o_cluster_used,
    output logic [icacc_pkg::CNT_W-1:0]         o_member_count,
    output logic signed [icacc_pkg::COORD_W-1:0] o_center_coord,
    output logic [icacc_pkg::DIM_W-1:0]         o_coord_echo
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIX  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam int LW = icacc_pkg::LABEL_W;
    localparam int CW = icacc_pkg::CNT_W;
    localparam int SW = icacc_pkg::SUM_W;
    localparam int VW = icacc_pkg::COORD_W;

    logic [2:0] r_state;

    logic [icacc_pkg::MAP_W-1:0] mem_map [icacc_pkg::POINT_SLOTS];
    logic [SW-1:0]               mem_sum [icacc_pkg::NUM_SUMS];
    logic [CW-1:0]               mem_cnt [icacc_pkg::NUM_CLUSTERS];

    logic [icacc_pkg::MAP_W-1:0] r_map_rd;
    logic [SW-1:0]               r_sum_rd;
    logic [CW-1:0]               r_cnt_rd;

    logic                        r_clr_busy;
    logic [icacc_pkg::SADDR_W-1:0] r_clr;

    logic                        r_op;
    logic [icacc_pkg::PID_W-1:0] r_pid;
    logic [LW-1:0]               r_lab;
    logic [icacc_pkg::DIM_W-1:0] r_ci;
    logic signed [VW-1:0]        r_val;

    logic                        r_act;
    logic                        r_status;
    logic [LW-1:0]               r_cl;
    logic [LW-1:0]               r_held_label;
    logic                        r_held_ok;
    logic [CW-1:0]               r_cnt_out;

    logic                        r_neg;
    logic [SW-1:0]               r_dvd;
    logic [SW-1:0]               r_quo;
    logic [CW-1:0]               r_rem;
    logic [CW-1:0]               r_dsr;
    logic [icacc_pkg::DIVC_W-1:0] r_dcnt;
    logic signed [VW-1:0]        r_center;

    logic                        r_oval;
    logic                        r_ostat;
    logic [LW-1:0]               r_ocl;
    logic [CW-1:0]               r_ocnt;
    logic signed [VW-1:0]        r_ocen;
    logic [icacc_pkg::DIM_W-1:0] r_oci;

    logic                        n_act;
    logic                        n_status;
    logic [LW-1:0]               n_cl;
    logic [icacc_pkg::SADDR_W-1:0] n_saddr;
    logic [CW-1:0]               n_cnt;
    logic [SW:0]                 n_sum_wide;
    logic [SW-1:0]               n_sum;
    logic [SW-1:0]               n_mag;
    logic [CW:0]                 n_rem_sh;
    logic                        n_qbit;
    logic [SW-1:0]               n_sq;
    logic                        n_first;
    logic                        n_accept;
    logic                        n_out_free;

    assign o_stall    = r_clr_busy || (r_state != ST_IDLE);
    assign n_accept   = i_valid && !o_stall;
    assign n_out_free = !r_oval || !i_stall;
    assign n_first    = (r_ci == '0);

    // cluster selection once the map entry is back
    always_comb begin
        n_act    = 1'b0;
        n_status = icacc_pkg::STATUS_OK;
        n_cl     = '0;
        if (r_op == icacc_pkg::REQ_INSERT) begin
            n_act = 1'b1;
            n_cl  = r_lab;
        end else if (n_first) begin
            if (r_map_rd[LW]) begin
                n_act = 1'b1;
                n_cl  = r_map_rd[LW-1:0];
            end else begin
                n_status = icacc_pkg::STATUS_MISSING;
            end
        end else if (r_held_ok) begin
            n_act = 1'b1;
            n_cl  = r_held_label;
        end else begin
            n_status = icacc_pkg::STATUS_MISSING;
        end
    end

    assign n_saddr = {n_cl, r_ci};

    always_comb begin
        n_cnt = r_cnt_rd;
        if (n_first) begin
            if (r_op == icacc_pkg::REQ_INSERT) begin
                if (r_cnt_rd != icacc_pkg::COUNT_MAX) n_cnt = r_cnt_rd + 1'b1;
            end else if (r_cnt_rd != '0) begin
                n_cnt = r_cnt_rd - 1'b1;
            end
        end
    end

    always_comb begin
        if (r_op == icacc_pkg::REQ_INSERT) begin
            n_sum_wide = {r_sum_rd[SW-1], r_sum_rd} + {{(SW+1-VW){r_val[VW-1]}}, r_val};
        end else begin
            n_sum_wide = {r_sum_rd[SW-1], r_sum_rd} - {{(SW+1-VW){r_val[VW-1]}}, r_val};
        end
        if (n_sum_wide[SW] != n_sum_wide[SW-1]) begin
            n_sum = n_sum_wide[SW] ? icacc_pkg::SUM_MIN : icacc_pkg::SUM_MAX;
        end else begin
            n_sum = n_sum_wide[SW-1:0];
        end
        n_mag = n_sum[SW-1] ? (~n_sum + 1'b1) : n_sum;
    end

    assign n_rem_sh = {r_rem, r_dvd[SW-1]};
    assign n_qbit   = (n_rem_sh >= {1'b0, r_dsr});
    assign n_sq     = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_map[r_clr[icacc_pkg::PID_W-1:0]] <= '0;
        end else if (r_state == ST_UPD && r_act && n_first) begin
            mem_map[r_pid] <= (r_op == icacc_pkg::REQ_INSERT) ? {1'b1, r_lab} : '0;
        end
        r_map_rd <= mem_map[i_point_id];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_sum[r_clr] <= '0;
        end else if (r_state == ST_UPD && r_act) begin
            mem_sum[{r_cl, r_ci}] <= n_sum;
        end
        r_sum_rd <= mem_sum[n_saddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_cnt[r_clr[LW-1:0]] <= '0;
        end else if (r_state == ST_UPD && r_act && n_first) begin
            mem_cnt[r_cl] <= n_cnt;
        end
        r_cnt_rd <= mem_cnt[n_cl];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_clr_busy   <= 1'b1;
            r_clr        <= '0;
            r_held_label <= '0;
            r_held_ok    <= 1'b0;
            r_oval       <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == {icacc_pkg::SADDR_W{1'b1}}) r_clr_busy <= 1'b0;
            end
            if (r_state == ST_OUT && n_out_free) begin
                r_oval <= 1'b1;
            end else if (r_oval && !i_stall) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_op    <= i_req_type;
                        r_pid   <= i_point_id;
                        r_lab   <= i_cluster_label;
                        r_ci    <= i_coord_index;
                        r_val   <= i_coord_value;
                        r_state <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    r_act    <= n_act;
                    r_status <= n_status;
                    r_cl     <= n_cl;
                    if (r_op == icacc_pkg::REQ_DELETE && n_first) begin
                        r_held_ok <= n_act;
                        if (n_act) r_held_label <= n_cl;
                    end
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_cnt_out <= r_act ? n_cnt : '0;
                    r_neg     <= n_sum[SW-1];
                    r_dvd     <= n_mag;
                    r_quo     <= '0;
                    r_rem     <= '0;
                    r_dsr     <= (n_cnt == '0) ? CW'(1) : n_cnt;
                    r_dcnt    <= '0;
                    r_center  <= '0;
                    if (!r_act) r_cl <= '0;
                    r_state   <= r_act ? ST_DIV : ST_OUT;
                end
                ST_DIV: begin
                    r_dvd <= {r_dvd[SW-2:0], 1'b0};
                    r_quo <= {r_quo[SW-2:0], n_qbit};
                    r_rem <= n_qbit ? CW'(n_rem_sh - {1'b0, r_dsr}) : n_rem_sh[CW-1:0];
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == icacc_pkg::DIVC_W'(SW - 1)) r_state <= ST_FIX;
                end
                ST_FIX: begin
                    if (!r_neg && r_quo > SW'((1 << (VW - 1)) - 1)) begin
                        r_center <= {1'b0, {(VW-1){1'b1}}};
                    end else if (r_neg && r_quo > (SW'(1) << (VW - 1))) begin
                        r_center <= {1'b1, {(VW-1){1'b0}}};
                    end else begin
                        r_center <= n_sq[VW-1:0];
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (n_out_free) begin
                        r_ostat <= r_status;
                        r_ocl   <= r_cl;
                        r_ocnt  <= r_cnt_out;
                        r_ocen  <= r_center;
                        r_oci   <= r_ci;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid        = r_oval;
    assign o_status       = r_ostat;
    assign o_cluster_used = r_ocl;
    assign o_member_count = r_ocnt;
    assign o_center_coord = r_ocen;
    assign o_coord_echo   = r_oci;

endmodule

### rtl/core/icacc_checker.sv
module icacc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic                                o_status,
    input logic [icacc_pkg::LABEL_W-1:0]       o_cluster_used,
    input logic [icacc_pkg::CNT_W-1:0]         o_member_count,
    input logic signed [icacc_pkg::COORD_W-1:0] o_center_coord,
    input logic [icacc_pkg::DIM_W-1:0]         o_coord_echo
);

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_reset_stalls_in: assert property (@(posedge i_clk) !i_rst_n |=> o_stall)
        else $error("input not stalled during clearing pass");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cluster_used)
            && $stable(o_center_coord) && $stable(o_coord_echo))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_cluster_used == '0 && o_member_count == '0
            && o_center_coord == '0)
        else $error("failed item carries cluster data");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken while one is in work");

endmodule

bind incremental_centroid_accumulator_core icacc_checker u_icacc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_cluster_used (o_cluster_used),
    .o_member_count (o_member_count),
    .o_center_coord (o_center_coord),
    .o_coord_echo   (o_coord_echo)
);
